// ----- hw/rtl/decimal_coord_to_fixed_point_assert.svh -----
// Assertion macros for the decimal coordinate parser.
// Used by the parse and format stages; no other dependencies.
`ifndef DECIMAL_COORD_TO_FIXED_POINT_ASSERT_SVH
`define DECIMAL_COORD_TO_FIXED_POINT_ASSERT_SVH
`ifndef SYNTHESIS
// expr holds at every edge out of reset
`define DCTF_ASSERT_HOLD(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("dctf assertion failed");
// ante implies cons in the same cycle
`define DCTF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dctf assertion failed");
// ante implies cons in the next cycle
`define DCTF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dctf assertion failed");
`else
`define DCTF_ASSERT_HOLD(lbl, clk, rst, expr)
`define DCTF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DCTF_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/dctf_pkg.sv -----
// Shared types, constants and helper functions of the decimal coordinate parser.
// No dependencies.
package dctf_pkg;

   localparam int unsigned FRAC_DIGITS_DEF = 7;

   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned MAG_W    = 32;
   localparam int unsigned DIGIT_W  = 4;
   localparam int unsigned EXP_W    = 4;   // scale exponent, up to nine
   localparam int unsigned POW_W    = 30;  // ten to the ninth fits
   localparam int unsigned PROD_W   = MAG_W + POW_W;

   localparam logic [MAG_W-1:0] SAT_MARK = {1'b1, {(MAG_W-1){1'b0}}};

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SYMBOL   = 2'd1,
      STATUS_DOTS     = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   // parse state captured at the terminator
   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic [EXP_W-1:0] scale_exp;
      logic             negative;
      logic             sym_err;
      logic             dot_err;
   } snap_type;

   // scaled magnitude plus flags
   typedef struct packed {
      logic [PROD_W-1:0] product;
      logic              negative;
      logic              sym_err;
      logic              dot_err;
   } prod_type;

   function automatic logic [POW_W-1:0] pow10(input logic [EXP_W-1:0] k);
      logic [POW_W-1:0] p;
      case (k)
         4'd0:    p = 30'd1;
         4'd1:    p = 30'd10;
         4'd2:    p = 30'd100;
         4'd3:    p = 30'd1000;
         4'd4:    p = 30'd10000;
         4'd5:    p = 30'd100000;
         4'd6:    p = 30'd1000000;
         4'd7:    p = 30'd10000000;
         4'd8:    p = 30'd100000000;
         4'd9:    p = 30'd1000000000;
         default: p = 30'd1;
      endcase
      return p;
   endfunction

   // v*10 + d, clamped at the saturation mark
   function automatic logic [MAG_W-1:0] mul_add(input logic [MAG_W-1:0] v,
                                                input logic [DIGIT_W-1:0] d);
      logic [MAG_W+3:0] r;
      r = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {{MAG_W{1'b0}}, d};
      if (r > {4'b0000, SAT_MARK}) begin
         return SAT_MARK;
      end
      return r[MAG_W-1:0];
   endfunction

endpackage

// ----- hw/rtl/dctf_parse.sv -----
// Character parse stage: per-character state update and terminator snapshot.
// Depends on dctf_pkg and the assertion macro header.
`include "decimal_coord_to_fixed_point_assert.svh"
module dctf_parse #(
   parameter int unsigned FRAC_DIGITS = dctf_pkg::FRAC_DIGITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [dctf_pkg::CHAR_W-1:0] ch,
   output logic                        snap_valid,
   input  logic                        snap_ready,
   output dctf_pkg::snap_type          snap
);

   localparam int unsigned CNT_W = $clog2(FRAC_DIGITS + 1);

   logic [dctf_pkg::MAG_W-1:0] acc_ff, acc_in;
   logic                       neg_ff, neg_in;
   logic [1:0]                 dot_cnt_ff, dot_cnt_in;
   logic [CNT_W-1:0]           frac_cnt_ff, frac_cnt_in;
   logic                       first_ff, first_in;
   logic                       stopped_ff, stopped_in;
   logic                       err_ff, err_in;
   logic                       snap_valid_ff, snap_valid_in;
   dctf_pkg::snap_type         snap_ff, snap_in;

   logic                         accept;
   logic                         is_digit;
   logic [dctf_pkg::CHAR_W-1:0]  digit_full;

   assign in_ready   = !snap_valid_ff || snap_ready;
   assign accept     = in_valid && in_ready;
   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;
   assign is_digit   = (ch >= dctf_pkg::CHAR_ZERO) && (ch <= dctf_pkg::CHAR_NINE);
   assign digit_full = ch - dctf_pkg::CHAR_ZERO;

   always_comb begin
      acc_in        = acc_ff;
      neg_in        = neg_ff;
      dot_cnt_in    = dot_cnt_ff;
      frac_cnt_in   = frac_cnt_ff;
      first_in      = first_ff;
      stopped_in    = stopped_ff;
      err_in        = err_ff;
      snap_valid_in = snap_valid_ff && !snap_ready;
      snap_in       = snap_ff;
      if (accept) begin
         if (ch == dctf_pkg::CHAR_NUL) begin
            snap_valid_in     = 1'b1;
            snap_in.mag       = acc_ff;
            snap_in.scale_exp = dctf_pkg::EXP_W'(FRAC_DIGITS)
                                - dctf_pkg::EXP_W'(frac_cnt_ff);
            snap_in.negative  = neg_ff;
            snap_in.sym_err   = err_ff;
            snap_in.dot_err   = (dot_cnt_ff > 2'd1);
            acc_in            = '0;
            neg_in            = 1'b0;
            dot_cnt_in        = 2'd0;
            frac_cnt_in       = '0;
            first_in          = 1'b1;
            stopped_in        = 1'b0;
            err_in            = 1'b0;
         end else begin
            first_in = 1'b0;
            if (!stopped_ff && !err_ff) begin
               if (first_ff && ch == dctf_pkg::CHAR_MINUS) begin
                  neg_in = 1'b1;
               end else if (is_digit) begin
                  acc_in = dctf_pkg::mul_add(acc_ff, digit_full[dctf_pkg::DIGIT_W-1:0]);
                  if (dot_cnt_ff != 2'd0) begin
                     frac_cnt_in = frac_cnt_ff + CNT_W'(1);
                     if (frac_cnt_in >= CNT_W'(FRAC_DIGITS)) begin
                        stopped_in = 1'b1;
                     end
                  end
               end else if (ch == dctf_pkg::CHAR_DOT) begin
                  if (dot_cnt_ff != 2'd2) begin
                     dot_cnt_in = dot_cnt_ff + 2'd1;
                  end
               end else begin
                  err_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         neg_ff        <= 1'b0;
         dot_cnt_ff    <= 2'd0;
         frac_cnt_ff   <= '0;
         first_ff      <= 1'b1;
         stopped_ff    <= 1'b0;
         err_ff        <= 1'b0;
         snap_valid_ff <= 1'b0;
      end else begin
         acc_ff        <= acc_in;
         neg_ff        <= neg_in;
         dot_cnt_ff    <= dot_cnt_in;
         frac_cnt_ff   <= frac_cnt_in;
         first_ff      <= first_in;
         stopped_ff    <= stopped_in;
         err_ff        <= err_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

   `DCTF_ASSERT_IMP(a_stop_full, clock, reset, stopped_ff, frac_cnt_ff == CNT_W'(FRAC_DIGITS))
   `DCTF_ASSERT_IMP(a_frac_after_dot, clock, reset, frac_cnt_ff != '0, dot_cnt_ff != 2'd0)
   `DCTF_ASSERT_NXT(a_term_clears, clock, reset, accept && ch == dctf_pkg::CHAR_NUL, first_ff && acc_ff == '0 && snap_valid_ff)

endmodule

// ----- hw/rtl/dctf_scale.sv -----
// Scale stage: multiplies the captured magnitude by ten per missing fraction digit.
// Depends on dctf_pkg.
module dctf_scale (
   input  logic               clock,
   input  logic               reset,
   input  logic               snap_valid,
   output logic               snap_ready,
   input  dctf_pkg::snap_type snap,
   output logic               prod_valid,
   input  logic               prod_ready,
   output dctf_pkg::prod_type prod
);

   logic               valid_ff, valid_in;
   dctf_pkg::prod_type prod_ff, prod_in;
   logic               load;

   assign snap_ready = !valid_ff || prod_ready;
   assign load       = snap_valid && snap_ready;
   assign prod_valid = valid_ff;
   assign prod       = prod_ff;

   always_comb begin
      valid_in = load || (valid_ff && !prod_ready);
      prod_in  = prod_ff;
      if (load) begin
         // 32x30 product; the clamp at the saturation mark shows up as any
         // bit at or above bit 31 and is resolved in the format stage
         prod_in.product  = dctf_pkg::PROD_W'(snap.mag)
                            * dctf_pkg::PROD_W'(dctf_pkg::pow10(snap.scale_exp));
         prod_in.negative = snap.negative;
         prod_in.sym_err  = snap.sym_err;
         prod_in.dot_err  = snap.dot_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ----- hw/rtl/dctf_format.sv -----
// Format stage: status priority, sign and the result output register.
// Depends on dctf_pkg and the assertion macro header.
`include "decimal_coord_to_fixed_point_assert.svh"
module dctf_format (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          prod_valid,
   output logic                          prod_ready,
   input  dctf_pkg::prod_type            prod,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [dctf_pkg::VALUE_W-1:0]  coord_value,
   output logic [dctf_pkg::STATUS_W-1:0] status
);

   logic                         valid_ff, valid_in;
   logic [dctf_pkg::VALUE_W-1:0] value_ff, value_in;
   dctf_pkg::status_type         status_ff, status_in;
   logic                         load;
   logic                         overflow;
   logic [dctf_pkg::MAG_W-1:0]   mag;

   assign prod_ready  = !valid_ff || rsp_ready;
   assign load        = prod_valid && prod_ready;
   assign rsp_valid   = valid_ff;
   assign coord_value = value_ff;
   assign status      = status_ff;

   assign overflow = |prod.product[dctf_pkg::PROD_W-1:dctf_pkg::MAG_W-1];
   assign mag      = prod.product[dctf_pkg::MAG_W-1:0];

   always_comb begin
      valid_in  = load || (valid_ff && !rsp_ready);
      value_in  = value_ff;
      status_in = status_ff;
      if (load) begin
         if (prod.sym_err) begin
            status_in = dctf_pkg::STATUS_SYMBOL;
         end else if (prod.dot_err) begin
            status_in = dctf_pkg::STATUS_DOTS;
         end else if (overflow) begin
            status_in = dctf_pkg::STATUS_OVERFLOW;
         end else begin
            status_in = dctf_pkg::STATUS_OK;
         end
         if (status_in != dctf_pkg::STATUS_OK) begin
            value_in = '0;
         end else if (prod.negative) begin
            value_in = '0 - mag;
         end else begin
            value_in = mag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      status_ff <= status_in;
   end

   `DCTF_ASSERT_IMP(a_err_zero, clock, reset, valid_ff && status_ff != dctf_pkg::STATUS_OK, value_ff == '0)
   `DCTF_ASSERT_IMP(a_ok_in_range, clock, reset, valid_ff && status_ff == dctf_pkg::STATUS_OK, value_ff != dctf_pkg::SAT_MARK)
   `DCTF_ASSERT_NXT(a_load_shows, clock, reset, load, valid_ff)

endmodule

// ----- hw/rtl/decimal_coord_to_fixed_point.sv -----
// Decimal coordinate to fixed-point converter, top level.
// Depends on dctf_pkg, dctf_parse, dctf_scale and dctf_format.
//
// Takes a signed decimal text such as -NNN.NNNNNNN, one character per
// transfer on the req_ channel, ended by a zero byte, and answers each
// terminator with one transfer on the rsp_ channel: the value times ten to
// the FRAC_DIGITS as a 32-bit two's complement integer, and a status
// (ok, unexpected symbol, multiple dots, overflow; value is zero unless ok).
// A leading minus sets the sign; after FRAC_DIGITS fraction digits the rest
// of the text is skipped. Throughput is one character per clock while the
// snapshot register is empty or being taken: the per-character update
// (accumulate times ten plus digit) is combinational into the parse state
// registers. A result passes these registers in order: the terminator edge
// captures the parse state, the scale stage registers the 32x30 multiply by
// a power of ten, and the format stage registers status and sign and
// raises rsp_tvalid.
// Both sides are skid-free register stages with per-stage ready, so text
// keeps flowing while a result waits to be taken, until the stages fill.
module decimal_coord_to_fixed_point #(
   parameter int unsigned FRAC_DIGITS = dctf_pkg::FRAC_DIGITS_DEF  // 1 to 9
) (
   input  logic        clock,
   input  logic        reset,
   // character input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   // result output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] coord_value
   output logic [7:0]  rsp_tuser    // [1:0] status, [7:2] zero
);

   logic                          snap_valid, snap_ready;
   dctf_pkg::snap_type            snap;
   logic                          prod_valid, prod_ready;
   dctf_pkg::prod_type            prod;
   logic [dctf_pkg::STATUS_W-1:0] status;

   // character state machine and terminator capture
   dctf_parse #(
      .FRAC_DIGITS(FRAC_DIGITS)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .ch         (req_tdata),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap)
   );

   // power-of-ten scaling
   dctf_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod       (prod)
   );

   // status, sign, output register
   dctf_format u_format (
      .clock       (clock),
      .reset       (reset),
      .prod_valid  (prod_valid),
      .prod_ready  (prod_ready),
      .prod        (prod),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .coord_value (rsp_tdata),
      .status      (status)
   );

   assign rsp_tuser = {6'b000000, status};

endmodule
